/* rtl/sha_pkg.sv */
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types, constants and round functions of the SHA-256 hash engine.
// ----------------------------------------------------------------------------
package sha_pkg;

   // one block word on its way from the packer to the compressor
   typedef struct packed {
      logic [31:0] word;
      logic        msg_last;
   } qentry_type;

   // queue status seen by both sides
   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   localparam logic [31:0] PAD_WORD = 32'h8000_0000;
   localparam logic [3:0]  LEN_HI_IDX = 4'd14;

   function automatic logic [31:0] init_hash(input logic [2:0] idx);
      logic [31:0] v;
      case (idx)
         3'd0: v = 32'h6a09e667;
         3'd1: v = 32'hbb67ae85;
         3'd2: v = 32'h3c6ef372;
         3'd3: v = 32'ha54ff53a;
         3'd4: v = 32'h510e527f;
         3'd5: v = 32'h9b05688c;
         3'd6: v = 32'h1f83d9ab;
         3'd7: v = 32'h5be0cd19;
         default: v = 32'h0;
      endcase
      return v;
   endfunction

   function automatic logic [31:0] round_k(input logic [5:0] r);
      logic [31:0] v;
      case (r)
         6'd0:  v = 32'h428a2f98; 6'd1:  v = 32'h71374491;
         6'd2:  v = 32'hb5c0fbcf; 6'd3:  v = 32'he9b5dba5;
         6'd4:  v = 32'h3956c25b; 6'd5:  v = 32'h59f111f1;
         6'd6:  v = 32'h923f82a4; 6'd7:  v = 32'hab1c5ed5;
         6'd8:  v = 32'hd807aa98; 6'd9:  v = 32'h12835b01;
         6'd10: v = 32'h243185be; 6'd11: v = 32'h550c7dc3;
         6'd12: v = 32'h72be5d74; 6'd13: v = 32'h80deb1fe;
         6'd14: v = 32'h9bdc06a7; 6'd15: v = 32'hc19bf174;
         6'd16: v = 32'he49b69c1; 6'd17: v = 32'hefbe4786;
         6'd18: v = 32'h0fc19dc6; 6'd19: v = 32'h240ca1cc;
         6'd20: v = 32'h2de92c6f; 6'd21: v = 32'h4a7484aa;
         6'd22: v = 32'h5cb0a9dc; 6'd23: v = 32'h76f988da;
         6'd24: v = 32'h983e5152; 6'd25: v = 32'ha831c66d;
         6'd26: v = 32'hb00327c8; 6'd27: v = 32'hbf597fc7;
         6'd28: v = 32'hc6e00bf3; 6'd29: v = 32'hd5a79147;
         6'd30: v = 32'h06ca6351; 6'd31: v = 32'h14292967;
         6'd32: v = 32'h27b70a85; 6'd33: v = 32'h2e1b2138;
         6'd34: v = 32'h4d2c6dfc; 6'd35: v = 32'h53380d13;
         6'd36: v = 32'h650a7354; 6'd37: v = 32'h766a0abb;
         6'd38: v = 32'h81c2c92e; 6'd39: v = 32'h92722c85;
         6'd40: v = 32'ha2bfe8a1; 6'd41: v = 32'ha81a664b;
         6'd42: v = 32'hc24b8b70; 6'd43: v = 32'hc76c51a3;
         6'd44: v = 32'hd192e819; 6'd45: v = 32'hd6990624;
         6'd46: v = 32'hf40e3585; 6'd47: v = 32'h106aa070;
         6'd48: v = 32'h19a4c116; 6'd49: v = 32'h1e376c08;
         6'd50: v = 32'h2748774c; 6'd51: v = 32'h34b0bcb5;
         6'd52: v = 32'h391c0cb3; 6'd53: v = 32'h4ed8aa4a;
         6'd54: v = 32'h5b9cca4f; 6'd55: v = 32'h682e6ff3;
         6'd56: v = 32'h748f82ee; 6'd57: v = 32'h78a5636f;
         6'd58: v = 32'h84c87814; 6'd59: v = 32'h8cc70208;
         6'd60: v = 32'h90befffa; 6'd61: v = 32'ha4506ceb;
         6'd62: v = 32'hbef9a3f7; 6'd63: v = 32'hc67178f2;
         default: v = 32'h0;
      endcase
      return v;
   endfunction

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic logic [31:0] big_sigma0(input logic [31:0] x);
      return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic logic [31:0] big_sigma1(input logic [31:0] x);
      return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   function automatic logic [31:0] small_sigma0(input logic [31:0] x);
      return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic logic [31:0] small_sigma1(input logic [31:0] x);
      return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

endpackage

/* rtl/sha_queue.sv */
// ----------------------------------------------------------------------------
// sha_queue
// Four-entry word queue between the packer and the compressor.
// ----------------------------------------------------------------------------
module sha_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  sha_pkg::qentry_type push_data,
   input  logic                pop,
   output sha_pkg::qentry_type pop_data,
   output sha_pkg::qstat_type  stat
);
   logic [1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff, count_in;
   sha_pkg::qentry_type mem_ff [4];

   // pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff + {1'b0, push};
      rd_ptr_in = rd_ptr_ff + {1'b0, pop};
      count_in  = count_ff + {2'b0, push} - {2'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         count_ff  <= 3'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data   = mem_ff[rd_ptr_ff];
   assign stat.full  = (count_ff == 3'd4);
   assign stat.empty = (count_ff == 3'd0);
endmodule

/* rtl/sha_packer.sv */
// ----------------------------------------------------------------------------
// sha_packer
// Packs message bytes into block words, counts the length and appends padding.
// ----------------------------------------------------------------------------
module sha_packer (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [31:0]         req_data_word,
   input  logic [2:0]          req_byte_count,
   input  logic                req_end_of_message,
   input  sha_pkg::qstat_type  qstat,
   output logic                push,
   output sha_pkg::qentry_type push_data
);
   localparam logic [2:0] ST_ACC  = 3'd0;
   localparam logic [2:0] ST_PAD  = 3'd1;
   localparam logic [2:0] ST_ZERO = 3'd2;
   localparam logic [2:0] ST_LHI  = 3'd3;
   localparam logic [2:0] ST_LLO  = 3'd4;

   logic [2:0]  state_ff, state_in;
   logic [31:0] acc_ff, acc_in;
   logic [1:0]  acc_cnt_ff, acc_cnt_in;
   logic [3:0]  widx_ff, widx_in;
   logic [60:0] len_ff, len_in;
   logic [2:0]  nbytes, total;
   logic [31:0] masked;
   logic [63:0] comb, bits;
   logic        accept;

   assign req_stall = (state_ff != ST_ACC) || qstat.full;
   assign accept    = req_valid && !req_stall;
   assign bits      = {len_ff, 3'b000};

   // byte merge of the held partial word with the new bytes
   always_comb begin
      nbytes = (req_byte_count > 3'd4) ? 3'd4 : req_byte_count;
      masked = req_data_word & ~(32'hffff_ffff >> {nbytes, 3'b000});
      comb   = {acc_ff, 32'h0} | ({masked, 32'h0} >> {acc_cnt_ff, 3'b000});
      total  = {1'b0, acc_cnt_ff} + nbytes;
   end

   // sequencer
   always_comb begin
      state_in   = state_ff;
      acc_in     = acc_ff;
      acc_cnt_in = acc_cnt_ff;
      len_in     = len_ff;
      push       = 1'b0;
      push_data  = '{word: 32'h0, msg_last: 1'b0};
      case (state_ff)
         ST_ACC: begin
            if (accept) begin
               len_in = len_ff + {58'h0, nbytes};
               if (total >= 3'd4) begin
                  push           = 1'b1;
                  push_data.word = comb[63:32];
                  acc_in         = comb[31:0];
                  acc_cnt_in     = total[1:0];
               end else begin
                  acc_in     = comb[63:32];
                  acc_cnt_in = total[1:0];
               end
               if (req_end_of_message) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            if (!qstat.full) begin
               push           = 1'b1;
               push_data.word = acc_ff | (sha_pkg::PAD_WORD >> {acc_cnt_ff, 3'b000});
               acc_in         = 32'h0;
               acc_cnt_in     = 2'd0;
               state_in       = ST_ZERO;
            end
         end
         ST_ZERO: begin
            if (widx_ff == sha_pkg::LEN_HI_IDX) begin
               state_in = ST_LHI;
            end else if (!qstat.full) begin
               push = 1'b1;
            end
         end
         ST_LHI: begin
            if (!qstat.full) begin
               push           = 1'b1;
               push_data.word = bits[63:32];
               state_in       = ST_LLO;
            end
         end
         ST_LLO: begin
            if (!qstat.full) begin
               push               = 1'b1;
               push_data.word     = bits[31:0];
               push_data.msg_last = 1'b1;
               len_in             = 61'h0;
               state_in           = ST_ACC;
            end
         end
         default: begin
            state_in = ST_ACC;
         end
      endcase
      widx_in = widx_ff + {3'b0, push};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_ACC;
         acc_ff     <= 32'h0;
         acc_cnt_ff <= 2'd0;
         widx_ff    <= 4'd0;
         len_ff     <= 61'h0;
      end else begin
         state_ff   <= state_in;
         acc_ff     <= acc_in;
         acc_cnt_ff <= acc_cnt_in;
         widx_ff    <= widx_in;
         len_ff     <= len_in;
      end
   end
endmodule

/* rtl/sha_compress.sv */
// ----------------------------------------------------------------------------
// sha_compress
// Loads 16 block words, runs 64 rounds and emits the digest at message end.
// ----------------------------------------------------------------------------
module sha_compress (
   input  logic                clock,
   input  logic                reset,
   input  sha_pkg::qstat_type  qstat,
   input  sha_pkg::qentry_type pop_data,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [31:0]         rsp_digest_word,
   output logic [2:0]          rsp_word_number,
   output logic                rsp_last_word
);
   localparam logic [1:0] ST_LOAD  = 2'd0;
   localparam logic [1:0] ST_ROUND = 2'd1;
   localparam logic [1:0] ST_ADD   = 2'd2;
   localparam logic [1:0] ST_OUT   = 2'd3;

   logic [1:0]  state_ff, state_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        last_ff, last_in;
   logic [31:0] w_ff [16];
   logic [31:0] v_ff [8];
   logic [31:0] h_ff [8];
   logic [31:0] w_new, t1, t2;
   logic        out_adv, out_valid_ff;
   logic [31:0] out_word_ff;
   logic [2:0]  out_num_ff;
   logic        out_last_ff;
   logic        load_done;

   assign pop       = (state_ff == ST_LOAD) && !qstat.empty;
   assign load_done = pop && (cnt_ff[3:0] == 4'd15);
   assign out_adv   = (state_ff == ST_OUT) && (!out_valid_ff || !rsp_stall);

   // schedule and round datapath
   always_comb begin
      w_new = sha_pkg::small_sigma1(w_ff[14]) + w_ff[9]
            + sha_pkg::small_sigma0(w_ff[1]) + w_ff[0];
      t1 = v_ff[7] + sha_pkg::big_sigma1(v_ff[4])
         + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]))
         + sha_pkg::round_k(cnt_ff) + w_ff[0];
      t2 = sha_pkg::big_sigma0(v_ff[0])
         + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
   end

   // control
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      last_in  = last_ff;
      case (state_ff)
         ST_LOAD: begin
            if (pop) begin
               cnt_in = cnt_ff + 6'd1;
               if (load_done) begin
                  last_in  = pop_data.msg_last;
                  cnt_in   = 6'd0;
                  state_in = ST_ROUND;
               end
            end
         end
         ST_ROUND: begin
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            cnt_in   = 6'd0;
            state_in = last_ff ? ST_OUT : ST_LOAD;
         end
         ST_OUT: begin
            if (out_adv) begin
               cnt_in = cnt_ff + 6'd1;
               if (cnt_ff[2:0] == 3'd7) begin
                  cnt_in   = 6'd0;
                  state_in = ST_LOAD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         cnt_ff   <= 6'd0;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         last_ff  <= last_in;
      end
   end

   // schedule shift line
   always_ff @(posedge clock) begin
      if (pop || (state_ff == ST_ROUND)) begin
         for (int i = 0; i < 15; i++) begin
            w_ff[i] <= w_ff[i+1];
         end
         w_ff[15] <= pop ? pop_data.word : w_new;
      end
   end

   // working variables
   always_ff @(posedge clock) begin
      if (load_done) begin
         for (int i = 0; i < 8; i++) begin
            v_ff[i] <= h_ff[i];
         end
      end else if (state_ff == ST_ROUND) begin
         v_ff[0] <= t1 + t2;
         v_ff[1] <= v_ff[0];
         v_ff[2] <= v_ff[1];
         v_ff[3] <= v_ff[2];
         v_ff[4] <= v_ff[3] + t1;
         v_ff[5] <= v_ff[4];
         v_ff[6] <= v_ff[5];
         v_ff[7] <= v_ff[6];
      end
   end

   // chain value
   always_ff @(posedge clock) begin
      if (reset || (out_adv && (cnt_ff[2:0] == 3'd7))) begin
         for (int i = 0; i < 8; i++) begin
            h_ff[i] <= sha_pkg::init_hash(3'(i));
         end
      end else if (state_ff == ST_ADD) begin
         for (int i = 0; i < 8; i++) begin
            h_ff[i] <= h_ff[i] + v_ff[i];
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_adv) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_adv) begin
         out_word_ff <= h_ff[cnt_ff[2:0]];
         out_num_ff  <= cnt_ff[2:0];
         out_last_ff <= (cnt_ff[2:0] == 3'd7);
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_digest_word = out_word_ff;
   assign rsp_word_number = out_num_ff;
   assign rsp_last_word   = out_last_ff;
endmodule

/* rtl/sha256_hash_engine.sv */
// ----------------------------------------------------------------------------
// sha256_hash_engine
// SHA-256 of a byte stream: packer, word queue and round compressor.
// ----------------------------------------------------------------------------
//  channel | direction | ports
//  req     | in        | req_data_word, req_byte_count, req_end_of_message
//  rsp     | out       | rsp_digest_word, rsp_word_number, rsp_last_word
//
//  the packer takes one word per cycle while it is not padding and the
//  four-entry queue has room; the compressor loads each 16-word block,
//  runs its 64 rounds and adds it to the hash before it pops new words
//  padding adds 3 to 18 queue words at message end, then eight digest words
//  synchronous reset restores the initial hash and empties the queue
//  rsp_stall holds the digest output register and the compressor behind it
module sha256_hash_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_data_word,
   input  logic [2:0]  req_byte_count,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_number,
   output logic        rsp_last_word
);
   logic                q_push, q_pop;
   sha_pkg::qentry_type q_wdata, q_rdata;
   sha_pkg::qstat_type  q_stat;

   sha_packer u_packer (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_word      (req_data_word),
      .req_byte_count     (req_byte_count),
      .req_end_of_message (req_end_of_message),
      .qstat              (q_stat),
      .push               (q_push),
      .push_data          (q_wdata)
   );

   sha_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .pop       (q_pop),
      .pop_data  (q_rdata),
      .stat      (q_stat)
   );

   sha_compress u_compress (
      .clock           (clock),
      .reset           (reset),
      .qstat           (q_stat),
      .pop_data        (q_rdata),
      .pop             (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_digest_word (rsp_digest_word),
      .rsp_word_number (rsp_word_number),
      .rsp_last_word   (rsp_last_word)
   );

   // queue never written when full
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(q_push && q_stat.full))
      else $error("word queue overflow");

   // queue never read when empty
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(q_pop && q_stat.empty))
      else $error("word queue underflow");

   // digest words come in order
   a_word_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_word |=>
      !rsp_valid || (rsp_word_number == $past(rsp_word_number) + 3'd1))
      else $error("digest word out of order");
endmodule
